// ===== rtl/core/sha256_pkg.sv =====
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int LenOffset  = 56;
    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word initial_h(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Start/finish handshake between the block control and the round engine.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_cmp_ctl;

endpackage

// ===== rtl/core/sha256_if.sv =====
`timescale 1ns / 1ps
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_msg;
    modport source (output valid, msg_byte, byte_present, end_of_msg, input ready);
    modport sink (input valid, msg_byte, byte_present, end_of_msg, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha256_ram.sv =====
`timescale 1ns / 1ps
module sha256_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/sha256_round.sv =====
`timescale 1ns / 1ps
// Compression engine: load 16 words from the block RAM, run 64 rounds with a
// 16-word schedule window, then fold into the chain RAM one word per cycle.
module sha256_round (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output sha256_pkg::t_cmp_ctl   o_ctl,
    output logic [5:0]             o_blk_raddr,
    input  logic [7:0]             i_blk_rdata,
    output logic [2:0]             o_ch_raddr,
    input  logic [31:0]            i_ch_rdata,
    output logic                   o_ch_we,
    output logic [2:0]             o_ch_waddr,
    output logic [31:0]            o_ch_wdata
);
    import sha256_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    t_word       r_w [16];
    t_word       r_v [8];
    logic [31:0] r_acc;
    logic [5:0]  rnd;
    t_word       w_new, w_cur, t1, t2, s0, s1;

    assign rnd = r_cnt[5:0];
    assign s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = s1 + r_w[9] + s0 + r_w[0];
    assign w_cur = r_w[0];
    assign t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(rnd) + w_cur;
    assign t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Load phase: count 0..72 covers 64 byte reads and 8 chain reads overlapped
    // at the tail; each word is captured in the cycle after its read address.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 7'd1;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: if (r_cnt == 7'd72) begin
                n_state = S_RND;
                n_cnt   = '0;
            end
            S_RND: if (r_cnt == 7'd63) begin
                n_state = S_FOLD;
                n_cnt   = '0;
            end
            S_FOLD: if (r_cnt == 7'd8) begin
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_blk_raddr = r_cnt[5:0];
    assign o_ch_raddr  = (r_state == S_LOAD) ? 3'(r_cnt - 7'd64) : r_cnt[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (r_cnt >= 7'd1 && r_cnt <= 7'd64) begin
                    r_acc <= {r_acc[23:0], i_blk_rdata};
                    if (r_cnt[1:0] == 2'd0) begin
                        for (int j = 0; j < 15; j++) begin
                            r_w[j] <= r_w[j+1];
                        end
                        r_w[15] <= {r_acc[23:0], i_blk_rdata};
                    end
                end
                if (r_cnt >= 7'd65) begin
                    for (int j = 0; j < 7; j++) begin
                        r_v[j] <= r_v[j+1];
                    end
                    r_v[7] <= i_ch_rdata;
                end
            end
            S_RND: begin
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                for (int j = 0; j < 15; j++) begin
                    r_w[j] <= r_w[j+1];
                end
                r_w[15] <= w_new;
            end
            S_FOLD: begin
                if (r_cnt >= 7'd1) begin
                    for (int j = 0; j < 7; j++) begin
                        r_v[j] <= r_v[j+1];
                    end
                    r_v[7] <= r_v[0];
                end
            end
            default: ;
        endcase
    end

    // Fold: chain word k is read at count k, added and written at count k+1.
    assign o_ch_we    = (r_state == S_FOLD) && (r_cnt >= 7'd1);
    assign o_ch_waddr = 3'(r_cnt - 7'd1);
    assign o_ch_wdata = i_ch_rdata + r_v[0];

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = (r_state != S_IDLE);
    assign o_ctl.done  = (r_state == S_DONE);
endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// After end of message the padding block is written and compressed, then digest words are
// read; a second padding block follows when padding spills, and a full last block is
// compressed first. Throughput: one byte per cycle while a block fills; a full block holds
// input while compressed (start, load, 64 rounds, fold, done); digest words are read one
// at a time, each after the last is taken. Reset: synchronous active-low; clears counters
// and control; an eight-word sweep reloads chain RAM before input and after each digest.
module sha256_stream_hasher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha256_in_if.sink         in_ch,
    sha256_out_if.source      out_ch
);
    import sha256_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;   // load initial hash into chain RAM
    localparam logic [2:0] S_FILL = 3'd1;   // accept bytes
    localparam logic [2:0] S_CMP  = 3'd2;   // compress a full data block
    localparam logic [2:0] S_PAD  = 3'd3;   // write pad/length bytes
    localparam logic [2:0] S_PCMP = 3'd4;   // compress a padding block
    localparam logic [2:0] S_OUT  = 3'd5;   // stream digest words

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic [5:0]  r_pad;
    logic        r_two;      // padding needs an extra block
    logic        r_second;   // writing/compressing the final padding block
    logic [3:0]  r_idx;      // init sweep and digest word index
    logic        r_start;
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_oidx;
    logic        r_rd_pend;

    t_cmp_ctl    ctl;
    logic [5:0]  rd_blk_addr;
    logic [7:0]  blk_rdata;
    logic [2:0]  eng_ch_raddr, eng_ch_waddr;
    logic [31:0] eng_ch_wdata, ch_rdata;
    logic        eng_ch_we;

    logic        blk_we;
    logic [5:0]  blk_waddr;
    logic [7:0]  blk_wdata, pad_byte;
    logic        ch_we;
    logic [2:0]  ch_waddr, ch_raddr;
    logic [31:0] ch_wdata;
    logic        acc;
    logic        out_fire;

    assign acc      = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (r_state == S_FILL);

    // Pad byte for the current position: 0x80 marker, zeros, then big-endian length.
    always_comb begin
        pad_byte = 8'h00;
        if (r_pad >= 6'(LenOffset) && !(r_two && !r_second)) begin
            pad_byte = r_total[8*(7-int'(r_pad[2:0])) +: 8];
        end else if (!r_second && r_pad == r_fill[5:0]) begin
            pad_byte = PadByte;
        end
    end

    always_comb begin
        blk_we    = 1'b0;
        blk_waddr = r_fill[5:0];
        blk_wdata = in_ch.msg_byte;
        if (r_state == S_FILL && acc && in_ch.byte_present) begin
            blk_we = 1'b1;
        end else if (r_state == S_PAD) begin
            blk_we    = (r_pad >= r_fill[5:0]) || r_second;
            blk_waddr = r_pad;
            blk_wdata = pad_byte;
        end
    end

    sha256_ram #(.Width(8), .Depth(BlockBytes)) u_blk (
        .i_clk  (i_clk),
        .i_we   (blk_we),
        .i_waddr(blk_waddr),
        .i_wdata(blk_wdata),
        .i_raddr(rd_blk_addr),
        .o_rdata(blk_rdata)
    );

    // Chain RAM: the engine owns it while busy; otherwise the control side
    // sweeps initial values or reads digest words. Issue the read of word 0
    // in the engine's done cycle so it is ready on entry to the output phase.
    always_comb begin
        ch_we    = eng_ch_we;
        ch_waddr = eng_ch_waddr;
        ch_wdata = eng_ch_wdata;
        ch_raddr = eng_ch_raddr;
        if (r_state == S_INIT) begin
            ch_we    = 1'b1;
            ch_waddr = r_idx[2:0];
            ch_wdata = initial_h(r_idx[2:0]);
        end else if (r_state == S_OUT || (r_state == S_PCMP && ctl.done)) begin
            ch_raddr = r_idx[2:0];
        end
    end

    sha256_ram #(.Width(32), .Depth(8)) u_chain (
        .i_clk  (i_clk),
        .i_we   (ch_we),
        .i_waddr(ch_waddr),
        .i_wdata(ch_wdata),
        .i_raddr(ch_raddr),
        .o_rdata(ch_rdata)
    );

    sha256_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .o_ctl      (ctl),
        .o_blk_raddr(rd_blk_addr),
        .i_blk_rdata(blk_rdata),
        .o_ch_raddr (eng_ch_raddr),
        .i_ch_rdata (ch_rdata),
        .o_ch_we    (eng_ch_we),
        .o_ch_waddr (eng_ch_waddr),
        .o_ch_wdata (eng_ch_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_fill    <= '0;
            r_bits    <= '0;
            r_idx     <= '0;
            r_start   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_second  <= 1'b0;
            r_two     <= 1'b0;
            r_pad     <= '0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd7) begin
                        r_idx   <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: if (acc) begin
                    // Count the byte, compress a full block; at end of message latch the length, decide block count.
                    if (in_ch.byte_present && r_fill == 7'd63) begin
                        r_fill  <= '0;
                        r_bits  <= r_bits + 64'd512;
                        r_start <= 1'b1;
                        r_state <= S_CMP;
                        r_two   <= in_ch.end_of_msg;
                    end else begin
                        if (in_ch.byte_present) begin
                            r_fill <= r_fill + 7'd1;
                        end
                        r_two <= 1'b0;
                        if (in_ch.end_of_msg) begin
                            r_state  <= S_PAD;
                            r_pad    <= '0;
                            r_second <= 1'b0;
                        end
                    end
                    if (in_ch.end_of_msg) begin
                        r_total <= r_bits + {54'd0, (r_fill + 7'(in_ch.byte_present)), 3'd0};
                    end
                end
                S_CMP: if (ctl.done) begin
                    // A full block closing the message leaves a pure padding block.
                    if (r_two) begin
                        r_state  <= S_PAD;
                        r_pad    <= '0;
                        r_second <= 1'b0;
                        r_two    <= 1'b0;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_PAD: begin
                    r_pad <= r_pad + 6'd1;
                    if (r_pad == 6'd0 && !r_second) begin
                        r_two <= (r_fill[5:0] >= 6'(LenOffset));
                    end
                    if (r_pad == 6'd63) begin
                        r_start <= 1'b1;
                        r_state <= S_PCMP;
                    end
                end
                S_PCMP: if (ctl.done) begin
                    if (r_two && !r_second) begin
                        r_second <= 1'b1;
                        r_pad    <= '0;
                        r_state  <= S_PAD;
                    end else begin
                        r_state   <= S_OUT;
                        r_idx     <= '0;
                        r_rd_pend <= 1'b1;
                    end
                end
                S_OUT: begin
                    // One read in flight at a time; hold the word until taken.
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_ovalid  <= 1'b1;
                        r_oword   <= ch_rdata;
                        r_oidx    <= r_idx[2:0];
                        r_idx     <= r_idx + 4'd1;
                    end else if (out_fire) begin
                        r_ovalid <= 1'b0;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_INIT;
                            r_idx   <= '0;
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_second <= 1'b0;
                            r_two   <= 1'b0;
                        end else begin
                            r_rd_pend <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign out_ch.valid       = r_ovalid;
    assign out_ch.digest_word = r_oword;
    assign out_ch.word_index  = r_oidx;
    assign out_ch.last_word   = (r_oidx == 3'd7);
endmodule

// ===== rtl/core/sha256_check.sv =====
`timescale 1ns / 1ps
module sha256_check (
    input logic              i_clk,
    input logic              i_rst_n,
    sha256_in_if.sink        in_ch,
    sha256_out_if.source     out_ch
);
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken during digest");
    a_out_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word)
        && $stable(out_ch.word_index)) else $error("stalled word changed");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
        else $error("last flag mismatch");
    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last_word |=> !out_ch.valid ##1
        (out_ch.valid && out_ch.word_index == $past(out_ch.word_index, 2) + 3'd1))
        else $error("word order broken");
endmodule

bind sha256_stream_hasher sha256_check u_check (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);
